// ----- rtl/core/glcd_pkg.sv -----
// Shared types and constants of the graphic LCD column controller.
`timescale 1ns / 1ps
package glcd_pkg;

  localparam int unsigned COLUMNS_DEF = 64;
  localparam int unsigned PAGES_DEF   = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0] REQ_CMD_WRITE   = 2'd0;
  localparam logic [1:0] REQ_STATUS_READ = 2'd1;
  localparam logic [1:0] REQ_DATA_WRITE  = 2'd2;
  localparam logic [1:0] REQ_DATA_READ   = 2'd3;

  localparam logic [1:0] KIND_DONE    = 2'd0;
  localparam logic [1:0] KIND_WRITTEN = 2'd1;
  localparam logic [1:0] KIND_IGNORED = 2'd2;

  localparam logic [7:0] LINE_MASK    = 8'b0011_1111;
  localparam logic [7:0] PAGE_MASK    = 8'b0000_0111;
  localparam logic [7:0] ONOFF_MASK   = 8'b0011_1110;
  localparam logic [7:0] ONOFF_BIT    = 8'b0000_0001;

  typedef enum logic [2:0] {
    OP_START_LINE,
    OP_PAGE,
    OP_COLUMN,
    OP_DISPLAY,
    OP_BAD,
    OP_STATUS,
    OP_WRITE,
    OP_READ
  } glcd_op_t;

  typedef struct packed {
    glcd_op_t   op;
    logic [7:0] arg;
  } glcd_item_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } glcd_state_t;

endpackage

// ----- rtl/core/glcd_column_controller.sv -----
// Top level of the graphic LCD column controller.
// An accepted bus word is written into the queue; once the back end pops it, its result is registered.
// Throughput: one word per cycle while out_ready is high, paced by the single display memory port.
// Reset: synchronous, active low; clears all address, flag and latch registers.
// After reset a clearing pass writes zero to all COLUMNS*PAGES memory bytes (512 bytes
// at the defaults), one byte a cycle, with in_ready held low.
`timescale 1ns / 1ps
module glcd_column_controller #(
  parameter int unsigned COLUMNS = glcd_pkg::COLUMNS_DEF,
  parameter int unsigned PAGES   = glcd_pkg::PAGES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_bus_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_result_kind,
  output logic [7:0] out_read_byte,
  output logic [5:0] out_write_column,
  output logic [2:0] out_write_page,
  output logic       out_display_enabled,
  output logic [5:0] out_first_line
);
  import glcd_pkg::*;

  logic       run;
  logic       push_valid, push_ready;
  logic       pop_valid, pop_ready;
  glcd_item_t push_item, pop_item;

  glcd_front u_front (
    .run         (run),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_bus_byte (in_bus_byte),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_item   (push_item)
  );

  glcd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  glcd_back #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .run                 (run),
    .pop_valid           (pop_valid),
    .pop_ready           (pop_ready),
    .pop_item            (pop_item),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_kind     (out_result_kind),
    .out_read_byte       (out_read_byte),
    .out_write_column    (out_write_column),
    .out_write_page      (out_write_page),
    .out_display_enabled (out_display_enabled),
    .out_first_line      (out_first_line)
  );

`ifndef SYNTH
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    !run |-> !in_ready)
    else $error("word accepted during memory clearing");

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    !run |-> !(pop_valid && pop_ready))
    else $error("queue popped during memory clearing");

  a_write_fields_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind != KIND_WRITTEN) |->
      (out_write_column == 6'd0) && (out_write_page == 3'd0))
    else $error("write address reported on a non-write result");

  a_read_byte_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind != KIND_DONE) |-> (out_read_byte == 8'd0))
    else $error("read byte driven on a write or ignored command");
`endif

endmodule

// ----- rtl/core/glcd_ram.sv -----
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module glcd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/glcd_front.sv -----
// Front end: accepts bus words and decodes them into queue items.
`timescale 1ns / 1ps
module glcd_front (
  input  logic                 run,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_req_type,
  input  logic [7:0]           in_bus_byte,
  output logic                 push_valid,
  input  logic                 push_ready,
  output glcd_pkg::glcd_item_t push_item
);
  import glcd_pkg::*;

  glcd_op_t op;

  always_comb begin
    op = OP_BAD;
    case (in_req_type)
      REQ_CMD_WRITE: begin
        if (in_bus_byte[7]) begin
          op = in_bus_byte[6] ? OP_START_LINE : OP_PAGE;
        end else if (in_bus_byte[6]) begin
          op = OP_COLUMN;
        end else if (in_bus_byte[5] && ((in_bus_byte & ONOFF_MASK) == ONOFF_MASK)) begin
          op = OP_DISPLAY;
        end else begin
          op = OP_BAD;
        end
      end
      REQ_STATUS_READ: op = OP_STATUS;
      REQ_DATA_WRITE:  op = OP_WRITE;
      REQ_DATA_READ:   op = OP_READ;
      default:         op = OP_BAD;
    endcase
  end

  assign in_ready      = run & push_ready;
  assign push_valid    = run & in_valid;
  assign push_item.op  = op;
  assign push_item.arg = in_bus_byte;

endmodule

// ----- rtl/core/glcd_queue.sv -----
// Short queue of decoded items between front and back end.
`timescale 1ns / 1ps
module glcd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  glcd_pkg::glcd_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output glcd_pkg::glcd_item_t pop_item
);
  import glcd_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

  glcd_item_t    entry_r [QUEUE_DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != NW'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = entry_r[rptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wptr_r] <= push_item;
    end
  end

endmodule

// ----- rtl/core/glcd_back.sv -----
// Back end: address registers, display memory access and result register.
`timescale 1ns / 1ps
module glcd_back #(
  parameter int unsigned COLUMNS = glcd_pkg::COLUMNS_DEF,
  parameter int unsigned PAGES   = glcd_pkg::PAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  output logic                 run,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  glcd_pkg::glcd_item_t pop_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_result_kind,
  output logic [7:0]           out_read_byte,
  output logic [5:0]           out_write_column,
  output logic [2:0]           out_write_page,
  output logic                 out_display_enabled,
  output logic [5:0]           out_first_line
);
  import glcd_pkg::*;

  localparam int unsigned CELLS = COLUMNS * PAGES;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned PW    = (PAGES > 1) ? $clog2(PAGES) : 1;

  glcd_state_t   state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [5:0]    col_r, col_nxt;
  logic [2:0]    page_r, page_nxt;
  logic [5:0]    start_r, start_nxt;
  logic          disp_r, disp_nxt;
  logic [7:0]    latch_r, latch_nxt;
  logic          pend_r, pend_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [7:0]    rbyte_r, rbyte_nxt;
  logic [5:0]    wcol_r, wcol_nxt;
  logic [2:0]    wpage_r, wpage_nxt;

  logic          clearing;
  logic          go;
  logic [7:0]    latch_cur;
  logic [4:0]    col_q_tab [64];
  logic [CW-1:0] col_r_tab [64];
  logic [PW-1:0] page_m_tab [64];
  logic [5:0]    page_sum;
  logic [AW-1:0] cell_idx;
  logic [6:0]    col_inc;
  logic [3:0]    page_inc;
  logic          col_wrap, page_wrap;
  logic [5:0]    col_adv;
  logic [2:0]    page_adv;

  logic          ram_en, ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;

  for (genvar g = 0; g < 64; g++) begin : g_tab
    localparam int unsigned CQ = g / COLUMNS;
    localparam int unsigned CR = g % COLUMNS;
    localparam int unsigned PM = g % PAGES;
    assign col_q_tab[g]  = 5'(CQ);
    assign col_r_tab[g]  = CW'(CR);
    assign page_m_tab[g] = PW'(PM);
  end

  assign page_sum = {3'b000, page_r} + {1'b0, col_q_tab[col_r]};
  assign cell_idx = AW'(page_m_tab[page_sum]) * AW'(COLUMNS) + AW'(col_r_tab[col_r]);

  assign col_inc   = {1'b0, col_r} + 7'd1;
  assign page_inc  = {1'b0, page_r} + 4'd1;
  assign col_wrap  = ({2'b00, col_inc} >= 9'(COLUMNS)) || col_inc[6];
  assign page_wrap = ({3'b000, page_inc} >= 7'(PAGES)) || page_inc[3];
  assign col_adv   = col_wrap ? 6'd0 : col_inc[5:0];
  assign page_adv  = !col_wrap ? page_r : (page_wrap ? 3'd0 : page_inc[2:0]);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_cnt_r == AW'(CELLS - 1)) state_nxt = ST_RUN;
      ST_RUN:   state_nxt = ST_RUN;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    clearing = 1'b0;
    run      = 1'b0;
    case (state_r)
      ST_CLEAR: clearing = 1'b1;
      ST_RUN:   run      = 1'b1;
      default:  clearing = 1'b1;
    endcase
  end

  assign pop_ready = run & (!out_valid_r | out_ready);
  assign go        = pop_valid & pop_ready;
  assign latch_cur = pend_r ? ram_rdata : latch_r;

  always_comb begin
    clr_cnt_nxt   = clearing ? clr_cnt_r + 1'b1 : clr_cnt_r;
    col_nxt       = col_r;
    page_nxt      = page_r;
    start_nxt     = start_r;
    disp_nxt      = disp_r;
    latch_nxt     = latch_cur;
    pend_nxt      = 1'b0;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    kind_nxt      = kind_r;
    rbyte_nxt     = rbyte_r;
    wcol_nxt      = wcol_r;
    wpage_nxt     = wpage_r;
    ram_en        = clearing;
    ram_we        = clearing;
    ram_addr      = clr_cnt_r;
    ram_wdata     = '0;
    if (go) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = KIND_DONE;
      rbyte_nxt     = '0;
      wcol_nxt      = '0;
      wpage_nxt     = '0;
      case (pop_item.op)
        OP_START_LINE: start_nxt = 6'(pop_item.arg & LINE_MASK);
        OP_PAGE:       page_nxt  = 3'(pop_item.arg & PAGE_MASK);
        OP_COLUMN:     col_nxt   = 6'(pop_item.arg & LINE_MASK);
        OP_DISPLAY:    disp_nxt  = |(pop_item.arg & ONOFF_BIT);
        OP_BAD:        kind_nxt  = KIND_IGNORED;
        OP_STATUS:     kind_nxt  = KIND_DONE;
        OP_WRITE: begin
          kind_nxt  = KIND_WRITTEN;
          wcol_nxt  = col_r;
          wpage_nxt = page_r;
          ram_en    = 1'b1;
          ram_we    = 1'b1;
          ram_addr  = cell_idx;
          ram_wdata = pop_item.arg;
          col_nxt   = col_adv;
          page_nxt  = page_adv;
        end
        OP_READ: begin
          rbyte_nxt = latch_cur;
          ram_en    = 1'b1;
          ram_we    = 1'b0;
          ram_addr  = cell_idx;
          pend_nxt  = 1'b1;
          col_nxt   = col_adv;
          page_nxt  = page_adv;
        end
        default: kind_nxt = KIND_IGNORED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      col_r       <= '0;
      page_r      <= '0;
      start_r     <= '0;
      disp_r      <= 1'b0;
      latch_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      col_r       <= col_nxt;
      page_r      <= page_nxt;
      start_r     <= start_nxt;
      disp_r      <= disp_nxt;
      latch_r     <= latch_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    rbyte_r <= rbyte_nxt;
    wcol_r  <= wcol_nxt;
    wpage_r <= wpage_nxt;
  end

  glcd_ram #(
    .WIDTH (8),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign out_valid           = out_valid_r;
  assign out_result_kind     = kind_r;
  assign out_read_byte       = rbyte_r;
  assign out_write_column    = wcol_r;
  assign out_write_page      = wpage_r;
  assign out_display_enabled = disp_r;
  assign out_first_line      = start_r;

endmodule

// ----- tb/tb_glcd_column_controller.sv -----
// Self-checking testbench for the graphic LCD column controller: directed and random bus words.
`timescale 1ns / 1ps
module tb_glcd_column_controller;
  import glcd_pkg::*;

  localparam int unsigned WORD_TARGET = 1550;
  localparam int unsigned HOLD_AT     = 400;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_AT    = 900;

  localparam logic [7:0] CMD_LINE   = 8'hC0;
  localparam logic [7:0] CMD_PAGE   = 8'h80;
  localparam logic [7:0] CMD_COLUMN = 8'h40;
  localparam logic [7:0] CMD_ONOFF  = 8'h3E;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rd_byte;
    logic [5:0] wr_column;
    logic [2:0] wr_page;
    logic       disp_on;
    logic [5:0] start_line;
  } lcd_result_t;

  typedef struct packed {
    logic [1:0]  req;
    logic [7:0]  data;
    logic        typed;
    lcd_result_t want;
  } bus_step_t;

  localparam lcd_result_t NO_CHECK = '0;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_req_type;
  logic [7:0] in_bus_byte;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] out_result_kind;
  logic [7:0] out_read_byte;
  logic [5:0] out_write_column;
  logic [2:0] out_write_page;
  logic       out_display_enabled;
  logic [5:0] out_first_line;

  logic [7:0] lcd_ram [COLUMNS_DEF*PAGES_DEF];
  logic [5:0] cur_column  = '0;
  logic [2:0] cur_page    = '0;
  logic [5:0] cur_line    = '0;
  logic       display_on  = 1'b0;
  logic [7:0] read_latch  = '0;

  lcd_result_t pending_results[$];
  int unsigned words_issued = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned req_seen [4] = '{0, 0, 0, 0};

  bus_step_t directed_steps [25] = '{
    {REQ_STATUS_READ, 8'hFF, 1'b1, KIND_DONE,    8'h00, 6'd0,  3'd0, 1'b0, 6'd0},
    {REQ_DATA_READ,   8'h5A, 1'b1, KIND_DONE,    8'h00, 6'd0,  3'd0, 1'b0, 6'd0},
    {REQ_CMD_WRITE,   8'h00, 1'b1, KIND_IGNORED, 8'h00, 6'd0,  3'd0, 1'b0, 6'd0},
    {REQ_CMD_WRITE,   8'h1F, 1'b1, KIND_IGNORED, 8'h00, 6'd0,  3'd0, 1'b0, 6'd0},
    {REQ_CMD_WRITE,   8'h20, 1'b1, KIND_IGNORED, 8'h00, 6'd0,  3'd0, 1'b0, 6'd0},
    {REQ_CMD_WRITE,   8'h3D, 1'b1, KIND_IGNORED, 8'h00, 6'd0,  3'd0, 1'b0, 6'd0},
    {REQ_CMD_WRITE,   8'h3F, 1'b1, KIND_DONE,    8'h00, 6'd0,  3'd0, 1'b1, 6'd0},
    {REQ_CMD_WRITE,   8'hFF, 1'b1, KIND_DONE,    8'h00, 6'd0,  3'd0, 1'b1, 6'd63},
    {REQ_CMD_WRITE,   8'hC0, 1'b1, KIND_DONE,    8'h00, 6'd0,  3'd0, 1'b1, 6'd0},
    {REQ_CMD_WRITE,   8'hBF, 1'b0, NO_CHECK},
    {REQ_CMD_WRITE,   8'h7F, 1'b0, NO_CHECK},
    {REQ_DATA_WRITE,  8'hFF, 1'b1, KIND_WRITTEN, 8'h00, 6'd63, 3'd7, 1'b1, 6'd0},
    {REQ_DATA_WRITE,  8'h00, 1'b1, KIND_WRITTEN, 8'h00, 6'd0,  3'd0, 1'b1, 6'd0},
    {REQ_CMD_WRITE,   8'hB8, 1'b0, NO_CHECK},
    {REQ_CMD_WRITE,   8'h40, 1'b0, NO_CHECK},
    {REQ_DATA_READ,   8'hFF, 1'b0, NO_CHECK},
    {REQ_DATA_READ,   8'h00, 1'b0, NO_CHECK},
    {REQ_CMD_WRITE,   8'hBF, 1'b0, NO_CHECK},
    {REQ_CMD_WRITE,   8'h7F, 1'b0, NO_CHECK},
    {REQ_DATA_READ,   8'h81, 1'b0, NO_CHECK},
    {REQ_DATA_READ,   8'h7E, 1'b0, NO_CHECK},
    {REQ_STATUS_READ, 8'h00, 1'b0, NO_CHECK},
    {REQ_CMD_WRITE,   8'h3E, 1'b1, KIND_DONE,    8'h00, 6'd0,  3'd0, 1'b0, 6'd0},
    {REQ_CMD_WRITE,   8'h80, 1'b0, NO_CHECK},
    {REQ_DATA_WRITE,  8'hA5, 1'b0, NO_CHECK}
  };

  glcd_column_controller u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_bus_byte         (in_bus_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_kind     (out_result_kind),
    .out_read_byte       (out_read_byte),
    .out_write_column    (out_write_column),
    .out_write_page      (out_write_page),
    .out_display_enabled (out_display_enabled),
    .out_first_line      (out_first_line)
  );

  always #5 clk = ~clk;

  function automatic int draw_idle_cycles(input int unsigned count);
    if ((count / 64) % 4 == 3) begin
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  function automatic void advance_address();
    if (int'(cur_column) + 1 >= COLUMNS_DEF) begin
      cur_column = '0;
      cur_page   = (int'(cur_page) + 1 >= PAGES_DEF) ? 3'd0 : cur_page + 3'd1;
    end else begin
      cur_column = cur_column + 6'd1;
    end
  endfunction

  function automatic lcd_result_t apply_bus_word(input logic [1:0] req, input logic [7:0] data);
    lcd_result_t r;
    int          ram_pos;
    r       = '0;
    ram_pos = (int'(cur_page) * COLUMNS_DEF + int'(cur_column)) % (COLUMNS_DEF * PAGES_DEF);
    case (req)
      REQ_CMD_WRITE: begin
        r.kind = KIND_DONE;
        if (data[7]) begin
          if (data[6]) cur_line = data[5:0];
          else cur_page = data[2:0];
        end else if (data[6]) begin
          cur_column = data[5:0];
        end else if (data[5] && ((data & ONOFF_MASK) == ONOFF_MASK)) begin
          display_on = |(data & ONOFF_BIT);
        end else begin
          r.kind = KIND_IGNORED;
        end
      end
      REQ_STATUS_READ: begin
        r.kind = KIND_DONE;
      end
      REQ_DATA_WRITE: begin
        r.kind      = KIND_WRITTEN;
        r.wr_column = cur_column;
        r.wr_page   = cur_page;
        lcd_ram[ram_pos] = data;
        advance_address();
      end
      default: begin
        r.kind    = KIND_DONE;
        r.rd_byte = read_latch;
        read_latch = lcd_ram[ram_pos];
        advance_address();
      end
    endcase
    r.disp_on    = display_on;
    r.start_line = cur_line;
    return r;
  endfunction

  task automatic issue_word(input logic [1:0] req, input logic [7:0] data, input logic typed,
                            input lcd_result_t want);
    int          gap;
    lcd_result_t model;
    gap = draw_idle_cycles(words_issued);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_bus_byte <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model = apply_bus_word(req, data);
    pending_results.push_back(typed ? want : model);
    words_issued++;
    req_seen[req]++;
  endtask

  task automatic note_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch on %s at result %0d: got %0d, expected %0d",
               what, results_checked, got, want);
    end
  endtask

  always @(posedge clk) begin : result_check
    lcd_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result word", out_result_kind, -1);
      end else begin
        want = pending_results.pop_front();
        if (out_result_kind !== want.kind)
          note_mismatch("result_kind", out_result_kind, want.kind);
        if (out_read_byte !== want.rd_byte)
          note_mismatch("read_byte", out_read_byte, want.rd_byte);
        if (out_write_column !== want.wr_column)
          note_mismatch("write_column", out_write_column, want.wr_column);
        if (out_write_page !== want.wr_page)
          note_mismatch("write_page", out_write_page, want.wr_page);
        if (out_display_enabled !== want.disp_on)
          note_mismatch("display_enabled", out_display_enabled, want.disp_on);
        if (out_first_line !== want.start_line)
          note_mismatch("first_line", out_first_line, want.start_line);
      end
      results_checked++;
    end
  end

  initial begin : result_sink
    int stall;
    int unsigned taken;
    bit held;
    taken     = 0;
    held      = 1'b0;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      stall = draw_idle_cycles(taken);
      if (!held && taken == HOLD_AT) begin
        stall = HOLD_CYCLES;
        held  = 1'b1;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin : bus_driver
    int         pick;
    int         run;
    logic [5:0] col;
    logic [2:0] pg;
    logic [5:0] last_col;
    logic [2:0] last_pg;
    logic [1:0] op;
    bit         drained;
    last_col    = '0;
    last_pg     = '0;
    drained     = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req_type = REQ_CMD_WRITE;
    in_bus_byte = '0;
    foreach (lcd_ram[i]) lcd_ram[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[i]) begin
      issue_word(directed_steps[i].req, directed_steps[i].data, directed_steps[i].typed,
                 directed_steps[i].want);
    end

    while (words_issued < WORD_TARGET) begin
      if (!drained && words_issued >= DRAIN_AT) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        drained = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        if ($urandom_range(0, 1) == 0) begin
          pg  = last_pg;
          col = last_col;
        end else begin
          pg  = 3'($urandom);
          col = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(56, 63)) : 6'($urandom);
        end
        last_pg  = pg;
        last_col = col;
        issue_word(REQ_CMD_WRITE, CMD_PAGE | {2'b00, 3'($urandom), pg}, 1'b0, NO_CHECK);
        issue_word(REQ_CMD_WRITE, CMD_COLUMN | {2'b00, col}, 1'b0, NO_CHECK);
        run = $urandom_range(1, 12);
        op  = $urandom_range(0, 1) ? REQ_DATA_WRITE : REQ_DATA_READ;
        repeat (run) issue_word(op, 8'($urandom), 1'b0, NO_CHECK);
      end else if (pick == 6) begin
        if ($urandom_range(0, 1) == 0)
          issue_word(REQ_CMD_WRITE, CMD_ONOFF | 8'($urandom_range(0, 1)), 1'b0, NO_CHECK);
        else
          issue_word(REQ_CMD_WRITE, CMD_LINE | 8'($urandom_range(0, 63)), 1'b0, NO_CHECK);
      end else if (pick == 7) begin
        issue_word(REQ_STATUS_READ, 8'($urandom), 1'b0, NO_CHECK);
      end else begin
        issue_word(2'($urandom), 8'($urandom), 1'b0, NO_CHECK);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Drove %0d bus words: %0d commands, %0d status reads, %0d writes, %0d reads",
             words_issued, req_seen[REQ_CMD_WRITE], req_seen[REQ_STATUS_READ],
             req_seen[REQ_DATA_WRITE], req_seen[REQ_DATA_READ]);
    $display("Checked %0d result words under random stalls, one long hold and one drain, %0d mismatches",
             results_checked, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/glcd_pkg.sv
rtl/core/glcd_ram.sv
rtl/core/glcd_front.sv
rtl/core/glcd_queue.sv
rtl/core/glcd_back.sv
rtl/core/glcd_column_controller.sv
tb/tb_glcd_column_controller.sv
